[hdl/mrtu_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
`default_nettype none

package mrtu_pkg;

  // Frame limits.
  localparam int MAX_FRAME    = 256;
  localparam int MIN_FRAME    = 3;
  localparam int HEADER_LEN   = 6;
  localparam int HEADER_IDX_W = $clog2(HEADER_LEN);
  localparam int COUNT_W      = $clog2(MAX_FRAME + 1);

  // CRC-16 constants (reflected form).
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Item function codes.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Function codes that carry start address and quantity.
  localparam logic [7:0] CODE_FIELDS_LO = 8'd1;
  localparam logic [7:0] CODE_FIELDS_HI = 8'd6;

  // Input item.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic        fields_valid;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } out_item_t;

  // Snapshot of the frame state handed to the result logic.
  typedef struct packed {
    logic [15:0]                   running_crc;
    logic [COUNT_W-1:0]            stored_count;
    logic [1:0][7:0]               tail_bytes;
    logic [HEADER_LEN-1:0][7:0]    header_bytes;
  } frame_state_t;

  // One byte of the reflected CRC-16, eight shift steps unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/mrtu_frame_state.sv]
// Frame state: running CRC, byte count, two-byte tail delay and captured header.
`default_nettype none

module mrtu_frame_state (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  mrtu_pkg::in_item_t     item,
  output mrtu_pkg::frame_state_t state
);

  logic [15:0]                            running_crc;
  logic [15:0]                            running_crc_next;
  logic [mrtu_pkg::COUNT_W-1:0]           stored_count;
  logic [mrtu_pkg::COUNT_W-1:0]           stored_count_next;
  logic [1:0][7:0]                        tail_bytes;
  logic [1:0][7:0]                        tail_bytes_next;
  logic [mrtu_pkg::HEADER_LEN-1:0][7:0]   header_bytes;
  logic [mrtu_pkg::HEADER_LEN-1:0][7:0]   header_bytes_next;

  // Next state: store a byte, or return to reset at end of frame.
  always_comb begin
    running_crc_next  = running_crc;
    stored_count_next = stored_count;
    tail_bytes_next   = tail_bytes;
    header_bytes_next = header_bytes;
    if (step) begin
      if (item.func == mrtu_pkg::FUNC_END) begin
        running_crc_next  = mrtu_pkg::CRC_INIT;
        stored_count_next = '0;
        tail_bytes_next   = '0;
        header_bytes_next = '0;
      end else if (stored_count < mrtu_pkg::COUNT_W'(mrtu_pkg::MAX_FRAME)) begin
        // The first bytes of the frame are kept as the header.
        if (stored_count < mrtu_pkg::COUNT_W'(mrtu_pkg::HEADER_LEN)) begin
          header_bytes_next[stored_count[mrtu_pkg::HEADER_IDX_W-1:0]] = item.data_byte;
        end
        // The byte leaving the delay line joins the CRC.
        if (stored_count >= mrtu_pkg::COUNT_W'(2)) begin
          running_crc_next = mrtu_pkg::crc16_byte(running_crc, tail_bytes[0]);
        end
        tail_bytes_next   = {item.data_byte, tail_bytes[1]};
        stored_count_next = stored_count + mrtu_pkg::COUNT_W'(1);
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= mrtu_pkg::CRC_INIT;
      stored_count <= '0;
      tail_bytes   <= '0;
      header_bytes <= '0;
    end else begin
      running_crc  <= running_crc_next;
      stored_count <= stored_count_next;
      tail_bytes   <= tail_bytes_next;
      header_bytes <= header_bytes_next;
    end
  end

  assign state.running_crc  = running_crc;
  assign state.stored_count = stored_count;
  assign state.tail_bytes   = tail_bytes;
  assign state.header_bytes = header_bytes;

endmodule

`default_nettype wire

[hdl/mrtu_result.sv]
// Frame check and result register with its output handshake.
`default_nettype none

module mrtu_result (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  mrtu_pkg::frame_state_t state,
  input  logic                   out_stall,
  output logic                   out_valid,
  output mrtu_pkg::out_item_t    out_data
);

  mrtu_pkg::out_item_t result_next;
  logic [15:0]         rcv;
  logic                ok;
  logic                fields;
  logic                out_valid_next;

  // Compare the CRCs and pick the header fields.
  always_comb begin
    rcv = '0;
    if (state.stored_count >= mrtu_pkg::COUNT_W'(2)) begin
      rcv = {state.tail_bytes[1], state.tail_bytes[0]};
    end
    ok = (state.stored_count >= mrtu_pkg::COUNT_W'(mrtu_pkg::MIN_FRAME)) &&
         (state.running_crc == rcv);
    fields = ok && (state.header_bytes[1] >= mrtu_pkg::CODE_FIELDS_LO) &&
             (state.header_bytes[1] <= mrtu_pkg::CODE_FIELDS_HI);
    result_next               = '0;
    result_next.frame_ok      = ok;
    result_next.fields_valid  = fields;
    result_next.computed_crc  = state.running_crc;
    result_next.received_crc  = rcv;
    if (ok) begin
      result_next.slave_address = state.header_bytes[0];
      result_next.function_code = state.header_bytes[1];
    end
    if (fields) begin
      result_next.start_address = {state.header_bytes[2], state.header_bytes[3]};
      result_next.quantity      = {state.header_bytes[4], state.header_bytes[5]};
    end
  end

  // Result valid: set on load, cleared when taken.
  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

[hdl/modbus_rtu_frame_checker_unit.sv]
// Top level of the Modbus RTU frame checker: input register, frame state and result stage.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    in_data  (func, data_byte)
//   out      output     out_valid / out_stall  out_data (frame check result)
//
// One item is taken every cycle while in_stall is low; a byte item updates the frame state in the cycle
// after it is accepted, using an unrolled eight-step CRC byte update.
// An end-of-frame item loads the result register once no untaken result is held there.
// rst is synchronous and returns the CRC to 0xFFFF and clears all frame state.
// in_stall rises only while an end-of-frame item waits for a result register
// that holds an untaken result under out_stall.
`default_nettype none

module modbus_rtu_frame_checker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrtu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mrtu_pkg::out_item_t out_data
);

  logic                   in_valid_q;
  logic                   in_valid_q_next;
  mrtu_pkg::in_item_t     in_q;
  logic                   accept;
  logic                   advance;
  logic                   is_end;
  mrtu_pkg::frame_state_t state;

  // The held item moves on unless it needs a result register that is still full.
  assign is_end   = (in_q.func == mrtu_pkg::FUNC_END);
  assign advance  = in_valid_q && !(is_end && out_valid && out_stall);
  assign in_stall = in_valid_q && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_q_next = in_valid_q;
    if (accept) begin
      in_valid_q_next = 1'b1;
    end else if (advance) begin
      in_valid_q_next = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  mrtu_frame_state u_state (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (in_q),
    .state (state)
  );

  mrtu_result u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && is_end),
    .state     (state),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // A new result appears only after an end-of-frame item moved on.
  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && is_end))
    else $error("result appeared without an end-of-frame item");

  // A good frame always has matching CRCs.
  a_ok_crc_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_ok) |-> (out_data.computed_crc == out_data.received_crc))
    else $error("frame_ok with CRC mismatch");

  // Decoded fields only for good frames.
  a_fields_need_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fields_valid) |-> out_data.frame_ok)
    else $error("fields_valid without frame_ok");

  // End of frame returns the state to reset.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && is_end) |=> (state.stored_count == '0 &&
                             state.running_crc == mrtu_pkg::CRC_INIT))
    else $error("frame state not cleared after end of frame");

  // Only an end-of-frame item can hold up the input.
  a_stall_only_end: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_valid_q && is_end))
    else $error("input stalled by a byte item");
`endif

endmodule

`default_nettype wire
